### rtl/u8u16_pkg.sv
// Shared types, constants and the lead-byte classifier for the UTF-8 to UTF-16 decoder.
package u8u16_pkg;

    localparam logic [15:0] REPLACEMENT_UNIT = 16'hFFFD;
    localparam logic [15:0] HIGH_SURR_BASE   = 16'hD800;
    localparam logic [15:0] LOW_SURR_BASE    = 16'hDC00;
    localparam logic [20:0] SUPP_BASE        = 21'h10000;
    localparam logic [1:0]  CONT_TAG         = 2'b10;

    typedef enum logic [2:0] {
        LEAD_ASCII,
        LEAD_TWO,
        LEAD_THREE,
        LEAD_FOUR,
        LEAD_BAD
    } t_lead;

    // One queue entry: replacement units first, then the units of a code point.
    typedef struct packed {
        logic [1:0]  rep_cnt;
        logic        has_cp;
        logic [20:0] code_point;
        logic        last;
    } t_cmd;

    function automatic t_lead classify_lead(input logic [7:0] b);
        t_lead kind;
        case (b) inside
            [8'h00:8'h7F]: kind = LEAD_ASCII;
            [8'hC0:8'hDF]: kind = LEAD_TWO;
            [8'hE0:8'hEF]: kind = LEAD_THREE;
            [8'hF0:8'hF7]: kind = LEAD_FOUR;
            default:       kind = LEAD_BAD;
        endcase
        return kind;
    endfunction

endpackage

### rtl/u8u16_front.sv
// Front end: tracks the open sequence and queues an entry when a byte yields units.
module u8u16_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [7:0]        i_byte,
    input  logic              i_eos,
    output logic              o_push,
    output u8u16_pkg::t_cmd   o_cmd
);

    logic [20:0]           r_pc;
    logic [20:0]           n_pc;
    logic [1:0]            r_exp;
    logic [1:0]            n_exp;
    logic                  is_cont;
    logic                  broken;
    logic                  lead_bad;
    logic [20:0]           joined;
    u8u16_pkg::t_lead      lead;
    u8u16_pkg::t_cmd       cmd;

    always_comb begin
        lead     = u8u16_pkg::classify_lead(i_byte);
        is_cont  = (i_byte[7:6] == u8u16_pkg::CONT_TAG);
        joined   = {r_pc[14:0], i_byte[5:0]};
        broken   = 1'b0;
        lead_bad = 1'b0;
        n_pc     = r_pc;
        n_exp    = r_exp;
        cmd      = '0;
        if ((r_exp != 2'd0) && is_cont) begin
            n_exp = r_exp - 2'd1;
            if (r_exp == 2'd1) begin
                cmd.has_cp     = 1'b1;
                cmd.code_point = joined;
                n_pc           = '0;
            end else begin
                n_pc = joined;
            end
        end else begin
            broken = (r_exp != 2'd0);
            n_pc   = '0;
            n_exp  = 2'd0;
            case (lead)
                u8u16_pkg::LEAD_ASCII: begin
                    cmd.has_cp     = 1'b1;
                    cmd.code_point = {13'd0, i_byte};
                end
                u8u16_pkg::LEAD_TWO: begin
                    n_pc  = {16'd0, i_byte[4:0]};
                    n_exp = 2'd1;
                end
                u8u16_pkg::LEAD_THREE: begin
                    n_pc  = {17'd0, i_byte[3:0]};
                    n_exp = 2'd2;
                end
                u8u16_pkg::LEAD_FOUR: begin
                    n_pc  = {18'd0, i_byte[2:0]};
                    n_exp = 2'd3;
                end
                default: begin
                    lead_bad = 1'b1;
                end
            endcase
            cmd.rep_cnt = {1'b0, broken} + {1'b0, lead_bad};
        end
        if (i_eos) begin
            if (n_exp != 2'd0) begin
                cmd.rep_cnt = cmd.rep_cnt + 2'd1;
            end
            n_pc     = '0;
            n_exp    = 2'd0;
            cmd.last = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc  <= '0;
            r_exp <= 2'd0;
        end else if (i_accept) begin
            r_pc  <= n_pc;
            r_exp <= n_exp;
        end
    end

    assign o_push = i_accept && ((cmd.rep_cnt != 2'd0) || cmd.has_cp);
    assign o_cmd  = cmd;

endmodule

### rtl/u8u16_queue.sv
// Small FIFO of decoded entries between the front end and the unit emitter.
module u8u16_queue #(
    parameter int DEPTH = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  u8u16_pkg::t_cmd   i_cmd,
    input  logic              i_pop,
    output logic              o_full,
    output logic              o_valid,
    output u8u16_pkg::t_cmd   o_head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    u8u16_pkg::t_cmd    r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic               do_push;
    logic               do_pop;

    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_IDX) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_IDX) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_full  = (r_count == FULL_CNT);
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd_ptr];

endmodule

### rtl/u8u16_back.sv
// Back end: expands queue entries into UTF-16 code units behind an output register.
module u8u16_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_head_valid,
    input  u8u16_pkg::t_cmd   i_head,
    output logic              o_pop,
    input  logic              i_ready,
    output logic              o_valid,
    output logic [15:0]       o_unit,
    output logic              o_last
);

    logic         r_valid;
    logic         r_phase;
    logic [15:0]  r_unit;
    logic         r_last;
    logic         big;
    logic [20:0]  v;
    logic [1:0]   cp_units;
    logic [1:0]   total;
    logic [1:0]   k;
    logic         is_final;
    logic         load;
    logic [15:0]  unit;

    always_comb begin
        big      = (i_head.code_point[20:16] != 5'd0);
        v        = i_head.code_point - u8u16_pkg::SUPP_BASE;
        cp_units = i_head.has_cp ? (big ? 2'd2 : 2'd1) : 2'd0;
        total    = i_head.rep_cnt + cp_units;
        is_final = ({1'b0, r_phase} == (total - 2'd1));
        k        = {1'b0, r_phase} - i_head.rep_cnt;
        if ({1'b0, r_phase} < i_head.rep_cnt) begin
            unit = u8u16_pkg::REPLACEMENT_UNIT;
        end else if (!big) begin
            unit = i_head.code_point[15:0];
        end else if (k[0] == 1'b0) begin
            unit = u8u16_pkg::HIGH_SURR_BASE + {5'd0, v[20:10]};
        end else begin
            unit = u8u16_pkg::LOW_SURR_BASE + {6'd0, v[9:0]};
        end
    end

    assign load  = i_head_valid && (!r_valid || i_ready);
    assign o_pop = load && is_final;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_phase <= 1'b0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_phase <= is_final ? 1'b0 : 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_unit <= unit;
            r_last <= i_head.last && is_final;
        end
    end

    assign o_valid = r_valid;
    assign o_unit  = r_unit;
    assign o_last  = r_last;

endmodule

### rtl/utf8_to_utf16_decoder.sv
// Top level of the streaming UTF-8 to UTF-16 decoder.
// Takes one UTF-8 byte per transaction and sustains one byte per clock cycle while the entry
// queue is not full; every code unit is its own transaction on the output port, so a byte that
// yields a surrogate pair or a replacement unit followed by another unit holds the output for
// two transactions, and the entry queue of QUEUE_DEPTH entries between the byte decoder and
// the unit emitter absorbs that burst. A unit is written into the entry queue and then into
// the output register before it appears on the output. Malformed input is replaced by U+FFFD;
// overlong forms, surrogate code points and values above U+10FFFF are not checked.
module utf8_to_utf16_decoder #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [15:0] code_unit
    output logic        m_axis_tlast
);

    logic              accept;
    logic              push;
    logic              pop;
    logic              full;
    logic              head_valid;
    u8u16_pkg::t_cmd   cmd;
    u8u16_pkg::t_cmd   head;

    assign s_axis_tready = !full;
    assign accept        = s_axis_tvalid && s_axis_tready;

    u8u16_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_byte   (s_axis_tdata),
        .i_eos    (s_axis_tlast),
        .o_push   (push),
        .o_cmd    (cmd)
    );

    u8u16_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd),
        .i_pop   (pop),
        .o_full  (full),
        .o_valid (head_valid),
        .o_head  (head)
    );

    u8u16_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (head_valid),
        .i_head       (head),
        .o_pop        (pop),
        .i_ready      (m_axis_tready),
        .o_valid      (m_axis_tvalid),
        .o_unit       (m_axis_tdata),
        .o_last       (m_axis_tlast)
    );

endmodule

### rtl/u8u16_checker.sv
// Port-level checks for the UTF-8 to UTF-16 decoder, bound to its top level.
module u8u16_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,
    input  logic        s_axis_tlast,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [15:0] m_axis_tdata,
    input  logic        m_axis_tlast
);

    // A stalled output transaction keeps its valid.
    a_out_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output valid dropped while stalled");

    // A stalled output transaction keeps its payload.
    a_out_data_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("output payload changed while stalled");

    // A full queue with an empty output register must present a unit on the next cycle.
    a_no_dead_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid && !s_axis_tready |=> m_axis_tvalid)
        else $error("input stalled with nothing on the output");

    // Reset leaves an empty pipeline that takes input at once.
    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid && s_axis_tready)
        else $error("pipeline not empty after reset");

endmodule

bind utf8_to_utf16_decoder u8u16_checker u_checker (.*);

### tb/utf8_to_utf16_decoder_test.sv
// Self-checking testbench for the streaming UTF-8 to UTF-16 decoder.
`timescale 1ns / 1ps

module utf8_to_utf16_decoder_test;

    localparam logic [15:0] REPLACEMENT = 16'hFFFD;
    localparam logic [15:0] HIGH_HALF   = 16'hD800;
    localparam logic [15:0] LOW_HALF    = 16'hDC00;
    localparam logic [20:0] PLANE_ONE   = 21'h10000;
    localparam int          LONG_HOLD   = 300;
    localparam int          DRAIN_LIMIT = 4000;

    typedef struct {
        logic [15:0] unit;
        logic        last;
    } t_utf16_unit;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;     // [7:0] data_byte
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;             // [15:0] code_unit
    logic        m_axis_tlast;

    t_utf16_unit utf16_expected[$];
    logic [20:0] pend_code = '0;
    logic [1:0]  pend_left = '0;

    int errors = 0;
    int bytes_sent = 0;
    int strings_sent = 0;
    int units_checked = 0;
    int pairs_predicted = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_asked = 0;
    int hold_served = 0;
    int hold_left = 0;

    utf8_to_utf16_decoder uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #10 i_clk = ~i_clk;

    function automatic void emit_unit(logic [15:0] unit);
        t_utf16_unit item;
        item.unit = unit;
        item.last = 1'b0;
        utf16_expected.insert(utf16_expected.size(), item);
    endfunction

    function automatic void emit_code_point(logic [20:0] cp);
        logic [20:0] offset;
        if (cp >= PLANE_ONE) begin
            offset = cp - PLANE_ONE;
            emit_unit(HIGH_HALF + {5'd0, offset[20:10]});
            emit_unit(LOW_HALF + {6'd0, offset[9:0]});
            pairs_predicted++;
        end else begin
            emit_unit(cp[15:0]);
        end
    endfunction

    function automatic void start_sequence(logic [7:0] b);
        if (b[7] == 1'b0) begin
            emit_code_point({13'd0, b});
        end else if (b[7:5] == 3'b110) begin
            pend_code = {16'd0, b[4:0]};
            pend_left = 2'd1;
        end else if (b[7:4] == 4'b1110) begin
            pend_code = {17'd0, b[3:0]};
            pend_left = 2'd2;
        end else if (b[7:3] == 5'b11110) begin
            pend_code = {18'd0, b[2:0]};
            pend_left = 2'd3;
        end else begin
            emit_unit(REPLACEMENT);
        end
    endfunction

    function automatic void predict_units(logic [7:0] b, logic eos);
        int queued_before;
        queued_before = utf16_expected.size();
        if (pend_left != 2'd0) begin
            if (b[7:6] == 2'b10) begin
                pend_code = {pend_code[14:0], b[5:0]};
                pend_left = pend_left - 2'd1;
                if (pend_left == 2'd0) begin
                    emit_code_point(pend_code);
                    pend_code = '0;
                end
            end else begin
                emit_unit(REPLACEMENT);
                pend_code = '0;
                pend_left = '0;
                start_sequence(b);
            end
        end else begin
            start_sequence(b);
        end
        if (eos) begin
            if (pend_left != 2'd0) begin
                emit_unit(REPLACEMENT);
            end
            pend_code = '0;
            pend_left = '0;
            if (utf16_expected.size() > queued_before) begin
                utf16_expected[utf16_expected.size() - 1].last = 1'b1;
            end
        end
    endfunction

    function automatic void check_unit(logic [15:0] unit, logic last);
        t_utf16_unit want;
        if (utf16_expected.size() == 0) begin
            errors++;
            $display("%0t: unexpected unit, expected none, actual %h last %b",
                     $time, unit, last);
        end else begin
            want = utf16_expected.pop_front();
            units_checked++;
            if (want.unit !== unit || want.last !== last) begin
                errors++;
                $display("%0t: unit mismatch, expected %h last %b, actual %h last %b",
                         $time, want.unit, want.last, unit, last);
            end
        end
    endfunction

    // Output side: checks every transaction and drives tready, with an optional long hold.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            check_unit(m_axis_tdata, m_axis_tlast);
        end
        if (hold_asked != hold_served) begin
            hold_served = hold_asked;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic eos);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= eos;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predict_units(b, eos);
        bytes_sent++;
        if (eos) begin
            strings_sent++;
        end
    endtask

    task automatic wait_for_units();
        int guard;
        s_axis_tvalid <= 1'b0;
        guard = 0;
        while (utf16_expected.size() != 0 && guard < DRAIN_LIMIT) begin
            @(posedge i_clk);
            guard++;
        end
        if (utf16_expected.size() != 0) begin
            errors++;
            $display("%0t: %0d expected units never arrived", $time, utf16_expected.size());
            utf16_expected.delete();
        end
        repeat (4) @(posedge i_clk);
    endtask

    // Builds strings of whole sequences with random payload bits, plus stray bytes and
    // sequences cut short, and sends them with tlast on the final byte.
    task automatic send_random_strings(input int target, input int lead_len);
        logic [7:0] text[$];
        int first;
        int kind;
        int len;
        int keep;
        first = bytes_sent;
        while (bytes_sent - first < target) begin
            text.delete();
            repeat ($urandom_range(1, 8)) begin
                kind = $urandom_range(99);
                len  = (lead_len != 0) ? lead_len : $urandom_range(1, 4);
                keep = len;
                if (kind < 10) begin
                    text.insert(text.size(), 8'($urandom_range(0, 255)));
                end else begin
                    if (kind < 22 && len > 1) begin
                        keep = $urandom_range(1, len - 1);
                    end
                    case (len)
                        1:       text.insert(text.size(), 8'($urandom_range(0, 127)));
                        2:       text.insert(text.size(), 8'hC0 | 8'($urandom_range(0, 31)));
                        3:       text.insert(text.size(), 8'hE0 | 8'($urandom_range(0, 15)));
                        default: text.insert(text.size(), 8'hF0 | 8'($urandom_range(0, 7)));
                    endcase
                    repeat (keep - 1) begin
                        text.insert(text.size(), 8'h80 | 8'($urandom_range(0, 63)));
                    end
                end
            end
            foreach (text[i]) begin
                send_byte(text[i], i == text.size() - 1);
            end
        end
        wait_for_units();
    endtask

    task automatic test_directed_bytes();
        logic [8:0] vectors[25] = '{
            9'h000, 9'h07F, 9'h0C2, 9'h080, 9'h0EF, 9'h0BF, 9'h0BF,
            9'h0F7, 9'h0BF, 9'h0BF, 9'h0BF, 9'h080, 9'h0FF, 9'h0C3, 9'h041,
            9'h0E2, 9'h0F0, 9'h09F, 9'h098, 9'h180, 9'h0E2, 9'h182,
            9'h0C3, 9'h1E2, 9'h1FE
        };
        foreach (vectors[i]) begin
            send_byte(vectors[i][7:0], vectors[i][8]);
        end
        wait_for_units();
    endtask

    task automatic test_light_sender_idle();
        send_idle_pct = 15;
        recv_idle_pct <= 53;
        send_random_strings(600, 0);
    endtask

    task automatic test_light_receiver_idle();
        send_idle_pct = 53;
        recv_idle_pct <= 15;
        send_random_strings(600, 0);
    endtask

    task automatic test_no_idle();
        send_idle_pct = 0;
        recv_idle_pct <= 0;
        send_random_strings(600, 0);
    endtask

    // Most four-byte sequences yield surrogate pairs, so a held receiver fills the queue fast.
    task automatic test_output_hold();
        send_idle_pct = 0;
        recv_idle_pct <= 0;
        hold_asked <= hold_asked + 1;
        send_random_strings(120, 4);
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        send_idle_pct = 15;
        recv_idle_pct <= 53;
        test_directed_bytes();
        test_light_sender_idle();
        test_light_receiver_idle();
        test_no_idle();
        test_output_hold();
        repeat (8) @(posedge i_clk);
        $display("Covered %0d bytes in %0d strings, %0d code units checked,", bytes_sent,
                 strings_sent, units_checked);
        $display("%0d surrogate pairs, under three idle mixes and one long output hold.",
                 pairs_predicted);
        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("%0t: timeout", $time);
        $display("Regression FAIL");
        $finish;
    end

endmodule
